// ----- rtl/lhmf_pkg.sv -----
// shared types, constants and helpers for the letter histogram block
`default_nettype none

package lhmf_pkg;

   localparam int COUNT_WIDTH      = 16;
   localparam int NUM_LETTERS      = 26;
   localparam int LETTER_WIDTH     = $clog2(NUM_LETTERS);
   localparam int CHAR_WIDTH       = 8;
   localparam int OUT_COUNT_WIDTH  = 16;
   localparam int TOTAL_WIDTH      = 16;
   localparam int EXT_WIDTH        = (COUNT_WIDTH > OUT_COUNT_WIDTH) ?
                                     COUNT_WIDTH : OUT_COUNT_WIDTH;

   localparam logic [COUNT_WIDTH-1:0] COUNT_CEIL = {COUNT_WIDTH{1'b1}};
   localparam logic [TOTAL_WIDTH-1:0] TOTAL_CEIL = {TOTAL_WIDTH{1'b1}};

   localparam logic [CHAR_WIDTH-1:0] UPPER_A = 8'h41;
   localparam logic [CHAR_WIDTH-1:0] UPPER_Z = 8'h5A;
   localparam logic [CHAR_WIDTH-1:0] LOWER_A = 8'h61;
   localparam logic [CHAR_WIDTH-1:0] LOWER_Z = 8'h7A;

   typedef struct packed {
      logic [CHAR_WIDTH-1:0] char_code;
      logic                  end_of_text;
   } lhmf_req_type;

   typedef struct packed {
      logic [OUT_COUNT_WIDTH-1:0] max_count;
      logic [LETTER_WIDTH-1:0]    most_letter;
      logic                       any_letter;
      logic [TOTAL_WIDTH-1:0]     total_letters;
      logic                       count_saturated;
   } lhmf_rsp_type;

   // per-cycle control from the input stage
   typedef struct packed {
      logic fire;
      logic last;
   } lhmf_ctl_type;

   // clamp a letter count to the width of the result field
   function automatic logic [OUT_COUNT_WIDTH-1:0] clamp_count(
      input logic [COUNT_WIDTH-1:0] value
   );
      logic [EXT_WIDTH-1:0] ext;
      logic [EXT_WIDTH-1:0] top;
      ext = EXT_WIDTH'(value);
      top = EXT_WIDTH'({OUT_COUNT_WIDTH{1'b1}});
      if (ext > top) begin
         return {OUT_COUNT_WIDTH{1'b1}};
      end
      return ext[OUT_COUNT_WIDTH-1:0];
   endfunction

endpackage

`default_nettype wire

// ----- rtl/lhmf_in_reg.sv -----
// input register stage and issue control
`default_nettype none

module lhmf_in_reg (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire lhmf_pkg::lhmf_req_type req_word,
   input  wire logic                  out_free,
   output lhmf_pkg::lhmf_ctl_type     ctl,
   output lhmf_pkg::lhmf_req_type     item
);
   import lhmf_pkg::*;

   logic         s1_valid_ff;
   logic         s1_valid_in;
   lhmf_req_type s1_word_ff;
   logic         fire;
   logic         accept;

   // a word without the end mark never needs the output slot
   assign fire      = s1_valid_ff && (!s1_word_ff.end_of_text || out_free);
   assign req_stall = s1_valid_ff && !fire;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (accept) begin
         s1_valid_in = 1'b1;
      end else begin
         s1_valid_in = s1_valid_ff && !fire;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_word_ff <= req_word;
      end
   end

   assign ctl.fire = fire;
   assign ctl.last = s1_word_ff.end_of_text;
   assign item     = s1_word_ff;

endmodule

`default_nettype wire

// ----- rtl/lhmf_hist.sv -----
// letter counters, running maximum and letter total
`default_nettype none

module lhmf_hist (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire lhmf_pkg::lhmf_ctl_type ctl,
   input  wire lhmf_pkg::lhmf_req_type item,
   output lhmf_pkg::lhmf_rsp_type      result
);
   import lhmf_pkg::*;

   logic [COUNT_WIDTH-1:0]  counts_ff [NUM_LETTERS];
   logic [COUNT_WIDTH-1:0]  best_count_ff;
   logic [COUNT_WIDTH-1:0]  best_count_in;
   logic [LETTER_WIDTH-1:0] best_letter_ff;
   logic [LETTER_WIDTH-1:0] best_letter_in;
   logic [TOTAL_WIDTH-1:0]  total_ff;
   logic [TOTAL_WIDTH-1:0]  total_in;
   logic                    sat_ff;
   logic                    sat_in;

   logic                    is_upper;
   logic                    is_lower;
   logic                    is_letter;
   logic [CHAR_WIDTH-1:0]   offset;
   logic [LETTER_WIDTH-1:0] idx;
   logic [COUNT_WIDTH-1:0]  cur;
   logic [COUNT_WIDTH-1:0]  nxt;
   logic                    bump;
   logic                    clear;

   assign is_upper  = (item.char_code >= UPPER_A) && (item.char_code <= UPPER_Z);
   assign is_lower  = (item.char_code >= LOWER_A) && (item.char_code <= LOWER_Z);
   assign is_letter = is_upper || is_lower;
   assign offset    = item.char_code - (is_upper ? UPPER_A : LOWER_A);
   assign idx       = offset[LETTER_WIDTH-1:0];
   assign cur       = counts_ff[idx];
   assign nxt       = cur + COUNT_WIDTH'(1);
   assign bump      = ctl.fire && is_letter && (cur != COUNT_CEIL);
   assign clear     = ctl.fire && ctl.last;

   always_comb begin
      best_count_in  = best_count_ff;
      best_letter_in = best_letter_ff;
      total_in       = total_ff;
      sat_in         = sat_ff;
      if (bump) begin
         if (nxt == COUNT_CEIL) begin
            sat_in = 1'b1;
         end
         if ((nxt > best_count_ff) || ((nxt == best_count_ff) && (idx < best_letter_ff))) begin
            best_count_in  = nxt;
            best_letter_in = idx;
         end
      end
      // total counts every letter, even one whose counter is pinned
      if (ctl.fire && is_letter && (total_ff != TOTAL_CEIL)) begin
         total_in = total_ff + TOTAL_WIDTH'(1);
         if (total_in == TOTAL_CEIL) begin
            sat_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         for (int i = 0; i < NUM_LETTERS; i++) begin
            counts_ff[i] <= '0;
         end
         best_count_ff  <= '0;
         best_letter_ff <= '0;
         total_ff       <= '0;
         sat_ff         <= 1'b0;
      end else begin
         if (bump) begin
            counts_ff[idx] <= nxt;
         end
         best_count_ff  <= best_count_in;
         best_letter_ff <= best_letter_in;
         total_ff       <= total_in;
         sat_ff         <= sat_in;
      end
   end

   assign result.max_count       = clamp_count(best_count_in);
   assign result.most_letter     = (total_in != '0) ? best_letter_in : '0;
   assign result.any_letter      = (total_in != '0);
   assign result.total_letters   = total_in;
   assign result.count_saturated = sat_in;

`ifndef SYNTH
   a_best_matches_counter: assert property (@(posedge clock) disable iff (reset)
      (best_letter_ff < LETTER_WIDTH'(NUM_LETTERS)) &&
      (counts_ff[best_letter_ff] == best_count_ff))
      else $error("running maximum does not match its letter counter");

   a_best_within_total: assert property (@(posedge clock) disable iff (reset)
      EXT_WIDTH'(clamp_count(best_count_ff)) <= EXT_WIDTH'(total_ff))
      else $error("best count exceeds letter total");

   a_clear_after_end: assert property (@(posedge clock) disable iff (reset)
      clear |=> (total_ff == '0) && (best_count_ff == '0) && !sat_ff)
      else $error("state not cleared after end of text");

   a_sat_sticky: assert property (@(posedge clock) disable iff (reset)
      (sat_ff && !clear) |=> sat_ff)
      else $error("saturation flag dropped within a text");
`endif

endmodule

`default_nettype wire

// ----- rtl/lhmf_out_reg.sv -----
// result register toward the response channel
`default_nettype none

module lhmf_out_reg (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire lhmf_pkg::lhmf_ctl_type ctl,
   input  wire lhmf_pkg::lhmf_rsp_type result,
   output logic                        out_free,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output lhmf_pkg::lhmf_rsp_type      rsp_word
);
   import lhmf_pkg::*;

   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   lhmf_rsp_type rsp_word_ff;
   logic         load;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign load     = ctl.fire && ctl.last;

   always_comb begin
      if (load) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_word_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

`default_nettype wire

// ----- rtl/letter_histogram_most_frequent.sv -----
// top level of the letter histogram with most-frequent-letter result
// usage:
//   req channel: one text byte per word (char_code) plus end_of_text on the
//     final byte; a word moves when req_valid is high and req_stall is low
//   letters a-z / A-Z are case-folded into 26 counters, other bytes skipped
//   rsp channel: one word per text, after the byte marked end_of_text, with
//     the highest count, its letter (ties to the lowest), any_letter, the
//     letter total and the saturation flag
// timing:
//   one byte per cycle while req_stall is low; the counter update plus
//   running-max compare happen while a word sits in the input register, and
//   the result register loads on the edge at which the final byte leaves the
//   input register; rsp_valid is driven from the result register
// reset: synchronous, clears all counters, the running maximum and both
//   valid registers
// stall: while a result waits under rsp_stall, bytes without the end mark
//   keep flowing; a second end mark holds in the input register and raises
//   req_stall until the waiting result is taken
`default_nettype none

module letter_histogram_most_frequent (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire lhmf_pkg::lhmf_req_type req_word,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output lhmf_pkg::lhmf_rsp_type      rsp_word
);
   import lhmf_pkg::*;

   lhmf_ctl_type ctl;
   lhmf_req_type item;
   lhmf_rsp_type result;
   logic         out_free;

   // input register, decides when the held byte may update the counters
   lhmf_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .out_free  (out_free),
      .ctl       (ctl),
      .item      (item)
   );

   // counters and running maximum, cleared after each end of text
   lhmf_hist u_hist (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .item   (item),
      .result (result)
   );

   // result register, separates the counters from the response stall
   lhmf_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .result    (result),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule

`default_nettype wire

// ----- tb/tb_letter_histogram_most_frequent.sv -----
// self-checking testbench for the letter histogram with most-frequent-letter result
`timescale 1ns / 100ps
`default_nettype none

module tb_letter_histogram_most_frequent;
   import lhmf_pkg::*;

   // cycles in a row with no word moving on either side before the run is called hung
   localparam int WATCHDOG_LIMIT = 400;
   // extra cycles waited once every summary has arrived, for margin
   localparam int DRAIN_CYCLES   = 8;
   localparam int RANDOM_BYTES   = 460;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   lhmf_req_type req_word  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   lhmf_rsp_type rsp_word;

   letter_histogram_most_frequent i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // predicted histogram state, mirrors what the block holds for the current text
   logic [COUNT_WIDTH-1:0]  letter_tally [NUM_LETTERS];
   logic [COUNT_WIDTH-1:0]  top_count;
   logic [LETTER_WIDTH-1:0] top_letter;
   logic [TOTAL_WIDTH-1:0]  text_letters;
   logic                    ceiling_hit;

   // summaries still owed by the block, oldest first
   lhmf_rsp_type pending_summaries [$];

   int  error_count = 0;
   bit  idling_on   = 1'b1;  // random gaps on both sides when set
   int  rsp_hold    = 5;     // stall cycles still owed before the next result is taken
   int  quiet_cycles;

   task automatic report_mismatch(input string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic clear_histogram();
      for (int i = 0; i < NUM_LETTERS; i++) begin
         letter_tally[i] = '0;
      end
      top_count    = '0;
      top_letter   = '0;
      text_letters = '0;
      ceiling_hit  = 1'b0;
   endtask

   // fold one accepted byte into the prediction; the end mark yields a summary
   task automatic tally_byte(input lhmf_req_type w);
      logic                    is_letter;
      logic [LETTER_WIDTH-1:0] idx;
      logic [63:0]             wide_top;
      lhmf_rsp_type            summary;
      is_letter = 1'b0;
      idx       = '0;
      if (w.char_code >= UPPER_A && w.char_code <= UPPER_Z) begin
         is_letter = 1'b1;
         idx       = LETTER_WIDTH'(w.char_code - UPPER_A);
      end else if (w.char_code >= LOWER_A && w.char_code <= LOWER_Z) begin
         is_letter = 1'b1;
         idx       = LETTER_WIDTH'(w.char_code - LOWER_A);
      end
      if (is_letter) begin
         // a letter counter sticks at its ceiling and then no longer competes
         if (letter_tally[idx] != COUNT_CEIL) begin
            letter_tally[idx] = letter_tally[idx] + 1'b1;
            if (letter_tally[idx] == COUNT_CEIL) begin
               ceiling_hit = 1'b1;
            end
            // ties go to the earlier letter
            if (letter_tally[idx] > top_count ||
                (letter_tally[idx] == top_count && idx < top_letter)) begin
               top_count  = letter_tally[idx];
               top_letter = idx;
            end
         end
         // the letter total has its own ceiling, which also raises the flag
         if (text_letters != TOTAL_CEIL) begin
            text_letters = text_letters + 1'b1;
            if (text_letters == TOTAL_CEIL) begin
               ceiling_hit = 1'b1;
            end
         end
      end
      if (w.end_of_text) begin
         wide_top = 64'(top_count);
         summary.max_count = (wide_top > 64'hFFFF) ? {OUT_COUNT_WIDTH{1'b1}} :
                             OUT_COUNT_WIDTH'(wide_top);
         // with no letters the letter field is pinned to a
         summary.most_letter     = (text_letters != '0) ? top_letter : '0;
         summary.any_letter      = (text_letters != '0);
         summary.total_letters   = text_letters;
         summary.count_saturated = ceiling_hit;
         pending_summaries.push_back(summary);
         clear_histogram();
      end
   endtask

   // drive one byte after a random gap and hold it until the block takes it;
   // valid stays high afterwards so back-to-back bytes never drop it
   task automatic send_byte(input logic [CHAR_WIDTH-1:0] c, input logic eot);
      int           gap;
      lhmf_req_type w;
      gap = idling_on ? $urandom_range(0, 7) : 0;
      w.char_code   = c;
      w.end_of_text = eot;
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_word  <= w;
      do begin
         @(posedge clock);
      end while (req_stall);
      tally_byte(w);
   endtask

   function automatic logic [CHAR_WIDTH-1:0] random_letter(input int span);
      logic [CHAR_WIDTH-1:0] base;
      base = $urandom_range(0, 1) ? UPPER_A : LOWER_A;
      return base + CHAR_WIDTH'($urandom_range(0, span - 1));
   endfunction

   // byte mix per text flavor: clustered letters (ties), prose, noise, letters only
   function automatic logic [CHAR_WIDTH-1:0] pick_char(input int flavor);
      int roll;
      roll = $urandom_range(0, 9);
      case (flavor)
         0: begin
            return (roll < 8) ? random_letter(3) : 8'h20;
         end
         1: begin
            if (roll < 6) begin
               return random_letter(NUM_LETTERS);
            end else if (roll < 8) begin
               return 8'h20;
            end
            return CHAR_WIDTH'($urandom_range(0, 255));
         end
         2: begin
            return CHAR_WIDTH'($urandom_range(0, 255));
         end
         default: begin
            return random_letter(NUM_LETTERS);
         end
      endcase
   endfunction

   // texts with only non-letters, range edges around both letter blocks,
   // case folding, tie-break and end mark on letter and on non-letter
   task automatic test_directed_edges();
      logic [CHAR_WIDTH-1:0] noise [9];
      noise = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h40, 8'h5B, 8'h60, 8'h7B, 8'h20};
      // no letters at all: zero count, letter pinned, any_letter low
      for (int i = 0; i < 9; i++) begin
         send_byte(noise[i], i == 8);
      end
      // z, a and b all reach two; the earliest letter must win
      send_byte("Z", 1'b0);
      send_byte("z", 1'b0);
      send_byte("A", 1'b0);
      send_byte("b", 1'b0);
      send_byte("B", 1'b0);
      send_byte("a", 1'b1);
      // single letter carrying the end mark
      send_byte("q", 1'b1);
      // end mark on a digit after one letter
      send_byte("M", 1'b0);
      send_byte("1", 1'b1);
      // lone end mark on a high byte
      send_byte(8'hFF, 1'b1);
   endtask

   // one-byte texts in a row so end marks pile up behind a stalled result
   task automatic test_back_to_back_ends();
      for (int i = 0; i < 16; i++) begin
         send_byte(pick_char(1), 1'b1);
      end
   endtask

   task automatic test_random_texts();
      int sent;
      int len;
      int flavor;
      sent = 0;
      while (sent < RANDOM_BYTES) begin
         len    = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 24);
         flavor = $urandom_range(0, 3);
         for (int i = 0; i < len; i++) begin
            send_byte(pick_char(flavor), i == len - 1);
         end
         sent += len;
      end
   endtask

   // result checker; also draws the stall before the next result is taken
   always @(posedge clock) begin
      lhmf_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_hold = idling_on ? $urandom_range(0, 7) : 0;
         if (pending_summaries.size() == 0) begin
            report_mismatch("result word with no text pending");
         end else begin
            want = pending_summaries.pop_front();
            if (rsp_word.max_count !== want.max_count) begin
               report_mismatch($sformatf("max_count got %0d want %0d",
                                         rsp_word.max_count, want.max_count));
            end
            if (rsp_word.most_letter !== want.most_letter) begin
               report_mismatch($sformatf("most_letter got %0d want %0d",
                                         rsp_word.most_letter, want.most_letter));
            end
            if (rsp_word.any_letter !== want.any_letter) begin
               report_mismatch($sformatf("any_letter got %b want %b",
                                         rsp_word.any_letter, want.any_letter));
            end
            if (rsp_word.total_letters !== want.total_letters) begin
               report_mismatch($sformatf("total_letters got %0d want %0d",
                                         rsp_word.total_letters, want.total_letters));
            end
            if (rsp_word.count_saturated !== want.count_saturated) begin
               report_mismatch($sformatf("count_saturated got %b want %b",
                                         rsp_word.count_saturated,
                                         want.count_saturated));
            end
         end
      end
   end

   // receiver back-pressure, changed on the falling edge only
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_stall <= 1'b1;
         rsp_hold  = rsp_hold - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // hang detector: counts cycles in which no word moves on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   initial begin
      clear_histogram();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_edges();
      test_back_to_back_ends();
      test_random_texts();

      @(negedge clock);
      req_valid <= 1'b0;
      // let every owed summary arrive, then a short drain
      while (pending_summaries.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

`default_nettype wire
